### hw/rtl/cdq_pkg.sv
// shared types and constants of the circular deque core
package cdq_pkg;

   localparam int VALUE_W = 32;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int OCC_W = 8;

   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic [VALUE_W-1:0] NONE_VALUE = 32'hFFFF_FFFF;

   // move request for one row of cells
   typedef struct packed {
      logic insert;  // shift up, new value enters the anchored cell
      logic remove;  // shift down toward the anchored cell
      logic append;  // write new value at the cell whose index equals the count
   } cdq_shift_type;

endpackage

### hw/rtl/circular_deque_core.sv
// double-ended queue built from two mirrored rows of shifting cells
//
// The core takes one item per clock cycle and returns one result per item in the
// cycle after the transfer, from an output register; req_tready stays high while
// that register is empty or being drained. Storage is two rows of DEPTH cells:
// one row keeps the front value in its first cell, the other keeps the back value
// in its first cell, so pops and the front/back readouts always come from fixed
// cells. A push at an end shifts the row anchored there and writes the other row
// at the cell that matches the fill count; a pop shifts the anchored row and
// leaves the other row alone. No clearing pass is needed after reset.
module circular_deque_core #(
   parameter int DEPTH = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,  // push_value[31:0]
   input  logic [2:0]   req_tuser,  // opcode[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // popped_value[31:0], occupancy[39:32], front_value[71:40], back_value[103:72]
   output logic [103:0] rsp_tdata,
   output logic [2:0]   rsp_tuser   // status[1:0], empty_flag[2]
);
   import cdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [103:0]   rsp_data_ff;
   logic [103:0]   rsp_data_in;
   logic [2:0]     rsp_user_ff;
   logic [2:0]     rsp_user_in;

   logic                      accept;
   logic [OPCODE_W-1:0]       opcode;
   logic signed [VALUE_W-1:0] push_value;
   logic                      is_full;
   logic                      count_zero;
   logic                      push_front_ok;
   logic                      push_back_ok;
   logic                      pop_front_ok;
   logic                      pop_back_ok;
   cdq_shift_type             front_ctrl;
   cdq_shift_type             back_ctrl;
   logic signed [VALUE_W-1:0] front_q;
   logic signed [VALUE_W-1:0] front_d;
   logic signed [VALUE_W-1:0] back_q;
   logic signed [VALUE_W-1:0] back_d;
   logic signed [VALUE_W-1:0] popped_value;
   logic [STATUS_W-1:0]       status;
   logic [CW+OCC_W-1:0]       count_wide;
   logic [OCC_W-1:0]          occupancy;
   logic                      empty_after;
   logic signed [VALUE_W-1:0] front_value;
   logic signed [VALUE_W-1:0] back_value;

   assign opcode     = req_tuser;
   assign push_value = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign is_full    = (count_ff == CW'(DEPTH));
   assign count_zero = (count_ff == '0);

   assign push_front_ok = accept && (opcode == OP_PUSH_FRONT) && !is_full;
   assign push_back_ok  = accept && (opcode == OP_PUSH_BACK) && !is_full;
   assign pop_front_ok  = accept && (opcode == OP_POP_FRONT) && !count_zero;
   assign pop_back_ok   = accept && (opcode == OP_POP_BACK) && !count_zero;

   assign front_ctrl = '{insert: push_front_ok, remove: pop_front_ok, append: push_back_ok};
   assign back_ctrl  = '{insert: push_back_ok, remove: pop_back_ok, append: push_front_ok};

   cdq_chain #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_front_chain (
      .clock      (clock),
      .ctrl       (front_ctrl),
      .count      (count_ff),
      .push_value (push_value),
      .anchor_q   (front_q),
      .anchor_d   (front_d)
   );

   cdq_chain #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_back_chain (
      .clock      (clock),
      .ctrl       (back_ctrl),
      .count      (count_ff),
      .push_value (push_value),
      .anchor_q   (back_q),
      .anchor_d   (back_d)
   );

   always_comb begin
      count_in = count_ff;
      if (push_front_ok || push_back_ok) begin
         count_in = count_ff + CW'(1);
      end else if (pop_front_ok || pop_back_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      popped_value = NONE_VALUE;
      if (pop_front_ok) begin
         popped_value = front_q;
      end else if (pop_back_ok) begin
         popped_value = back_q;
      end
   end

   always_comb begin
      status = ST_OK;
      case (opcode) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (is_full) begin
               status = ST_FULL;
            end
         end
         default: begin
            // pops and peeks (unused codes act as peek)
            if (count_zero) begin
               status = ST_EMPTY;
            end
         end
      endcase
   end

   assign count_wide  = {{OCC_W{1'b0}}, count_in};
   assign occupancy   = count_wide[OCC_W-1:0];
   assign empty_after = (count_in == '0);
   assign front_value = empty_after ? NONE_VALUE : front_d;
   assign back_value  = empty_after ? NONE_VALUE : back_d;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {back_value, front_value, occupancy, popped_value};
         rsp_user_in  = {empty_after, status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### hw/rtl/cdq_cell.sv
// one storage cell of a deque row
module cdq_cell #(
   parameter int INDEX = 0,
   parameter int CW = 8
) (
   input  logic                 clock,
   input  cdq_pkg::cdq_shift_type ctrl,
   input  logic [CW-1:0]        count,
   input  logic signed [31:0]   push_value,
   input  logic signed [31:0]   lower_value,
   input  logic signed [31:0]   upper_value,
   output logic signed [31:0]   value_q,
   output logic signed [31:0]   value_d
);
   import cdq_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         value_in = lower_value;
      end else if (ctrl.remove) begin
         value_in = upper_value;
      end else if (ctrl.append && (count == CW'(INDEX))) begin
         value_in = push_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_q = value_ff;
   assign value_d = value_in;

endmodule

### hw/rtl/cdq_chain.sv
// row of deque cells anchored at cell zero, each passing data to its neighbors
module cdq_chain #(
   parameter int DEPTH = 128,
   parameter int CW = 8
) (
   input  logic                   clock,
   input  cdq_pkg::cdq_shift_type ctrl,
   input  logic [CW-1:0]          count,
   input  logic signed [31:0]     push_value,
   output logic signed [31:0]     anchor_q,
   output logic signed [31:0]     anchor_d
);
   import cdq_pkg::*;

   logic signed [VALUE_W-1:0] cell_q [DEPTH];
   logic signed [VALUE_W-1:0] cell_d [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] lower_value;
      logic signed [VALUE_W-1:0] upper_value;

      if (i == 0) begin : g_first
         assign lower_value = push_value;
      end else begin : g_mid_lo
         assign lower_value = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign upper_value = cell_q[i];
      end else begin : g_mid_hi
         assign upper_value = cell_q[i+1];
      end

      cdq_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count),
         .push_value  (push_value),
         .lower_value (lower_value),
         .upper_value (upper_value),
         .value_q     (cell_q[i]),
         .value_d     (cell_d[i])
      );
   end

   assign anchor_q = cell_q[0];
   assign anchor_d = cell_d[0];

endmodule
